// File: rtl/genotype_cooccurrence_matrix_core_defines.svh
// Assertion macros for the genotype co-occurrence matrix block.
// Each macro checks on the rising edge of i_clk and is off while i_rst_n is low.
// Define ASSERT_OFF to compile the checks away.
`ifndef GENOTYPE_COOCCURRENCE_MATRIX_CORE_DEFINES_SVH
`define GENOTYPE_COOCCURRENCE_MATRIX_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define GCM_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("gcm assertion failed");

`define GCM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("gcm assertion failed");

`else

`define GCM_ASSERT_IMPLY(label, pre, post)

`define GCM_ASSERT_NEXT(label, pre, post)

`endif

`endif

// File: rtl/gcm_pkg.sv
`default_nettype none

package gcm_pkg;

    localparam int unsigned MAX_SAMPLES      = 64;
    localparam int unsigned SAMPLE_W         = 6;
    localparam int unsigned ADDR_W           = 2 * SAMPLE_W;
    localparam int unsigned COUNT_WIDTH      = 32;
    localparam int unsigned NUM_W            = 7;

    typedef logic [SAMPLE_W-1:0]    t_sample;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [NUM_W-1:0]       t_num;
    typedef logic [MAX_SAMPLES-1:0] t_carriers;

    localparam t_num   MAX_SAMPLES_NUM = t_num'(MAX_SAMPLES);

    localparam logic [7:0] NL_BYTE      = 8'd10;
    localparam logic [7:0] TAB_BYTE     = 8'd9;
    localparam logic [7:0] HASH_BYTE    = 8'd35;
    localparam logic [7:0] ZERO_BYTE    = 8'd48;
    localparam logic [7:0] BIG_N_BYTE   = 8'd78;
    localparam logic [7:0] SMALL_A_BYTE = 8'd97;
    localparam logic [7:0] FIRST_SAMPLE_TAB = 8'd9;

    localparam logic ACT_STREAM = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic           action;
        logic [7:0]     text_byte;
        t_sample        row_sample;
        t_sample        col_sample;
    } t_in_word;

    typedef struct packed {
        t_count         pair_count;
    } t_out_word;

    // Line end from the parser: pulse plus the carriers of the finished line.
    typedef struct packed {
        logic           done;
        t_carriers      carriers;
    } t_line;

endpackage

`default_nettype wire

// File: rtl/gcm_ifs.sv
`default_nettype none

interface gcm_in_if;
    logic               valid;
    logic               ready;
    gcm_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gcm_out_if;
    logic               valid;
    logic               ready;
    gcm_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/gcm_parse.sv
`default_nettype none

module gcm_parse (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_byte_en,
    input  wire logic [7:0]     i_byte,
    input  wire gcm_pkg::t_num  i_num_samples,
    output gcm_pkg::t_line      o_line
);

    gcm_pkg::t_carriers r_carrier, n_carrier;
    logic [7:0]         r_tab, n_tab;
    gcm_pkg::t_num      r_sidx, n_sidx;
    logic [1:0]         r_off, n_off;
    logic               r_fz, n_fz;
    logic               r_hr, n_hr;
    logic [1:0]         r_np, n_np;
    logic               r_ns, n_ns;
    logic               r_prev_tab, n_prev_tab;
    logic               r_hdr, n_hdr;
    logic               r_start, n_start;
    logic               r_open, n_open;

    gcm_pkg::t_num      w_limit;
    gcm_pkg::t_carriers w_final;
    logic               w_done;

    always_comb begin
        w_limit = (i_num_samples > gcm_pkg::MAX_SAMPLES_NUM) ? gcm_pkg::MAX_SAMPLES_NUM
                                                              : i_num_samples;

        // Carriers as they stand if the line ended now: an open field closes.
        w_final = r_carrier;
        if (r_open && (r_sidx < w_limit) && !r_ns && !r_hr) begin
            w_final[r_sidx[gcm_pkg::SAMPLE_W-1:0]] = 1'b1;
        end

        n_carrier  = r_carrier;
        n_tab      = r_tab;
        n_sidx     = r_sidx;
        n_off      = r_off;
        n_fz       = r_fz;
        n_hr       = r_hr;
        n_np       = r_np;
        n_ns       = r_ns;
        n_prev_tab = r_prev_tab;
        n_hdr      = r_hdr;
        n_start    = r_start;
        n_open     = r_open;
        w_done     = 1'b0;

        if (i_byte_en) begin
            if (i_byte == gcm_pkg::NL_BYTE) begin
                w_done     = !r_hdr;
                n_carrier  = '0;
                n_tab      = '0;
                n_sidx     = '0;
                n_off      = '0;
                n_fz       = 1'b0;
                n_hr       = 1'b0;
                n_np       = '0;
                n_ns       = 1'b0;
                n_prev_tab = 1'b0;
                n_hdr      = 1'b0;
                n_start    = 1'b1;
                n_open     = 1'b0;
            end else begin
                if (r_start) begin
                    n_start = 1'b0;
                    if (i_byte == gcm_pkg::HASH_BYTE) begin
                        n_hdr = 1'b1;
                    end
                end
                if (!n_hdr) begin
                    // Open a sample field on the first byte after a sample tab.
                    if (r_prev_tab && (r_tab >= gcm_pkg::FIRST_SAMPLE_TAB)) begin
                        n_open = 1'b1;
                        n_off  = '0;
                        n_fz   = 1'b0;
                        n_hr   = 1'b0;
                        n_np   = '0;
                        n_ns   = 1'b0;
                    end
                    if (n_open) begin
                        if (i_byte == gcm_pkg::TAB_BYTE) begin
                            if ((r_sidx < w_limit) && !n_ns && !n_hr) begin
                                n_carrier[r_sidx[gcm_pkg::SAMPLE_W-1:0]] = 1'b1;
                            end
                            if (r_sidx < gcm_pkg::MAX_SAMPLES_NUM) begin
                                n_sidx = r_sidx + gcm_pkg::t_num'(1);
                            end
                            n_open = 1'b0;
                        end else begin
                            if (n_off == 2'd0) begin
                                n_fz = (i_byte == gcm_pkg::ZERO_BYTE);
                            end else if ((n_off == 2'd2) && n_fz &&
                                         (i_byte == gcm_pkg::ZERO_BYTE)) begin
                                n_hr = 1'b1;
                            end
                            if (n_off != 2'd3) begin
                                n_off = n_off + 2'd1;
                            end
                            if ((n_np == 2'd2) && (i_byte == gcm_pkg::BIG_N_BYTE)) begin
                                n_ns = 1'b1;
                            end
                            if ((n_np == 2'd1) && (i_byte == gcm_pkg::SMALL_A_BYTE)) begin
                                n_np = 2'd2;
                            end else begin
                                n_np = (i_byte == gcm_pkg::BIG_N_BYTE) ? 2'd1 : 2'd0;
                            end
                        end
                    end
                    if (i_byte == gcm_pkg::TAB_BYTE) begin
                        if (r_tab != 8'hFF) begin
                            n_tab = r_tab + 8'd1;
                        end
                        n_prev_tab = 1'b1;
                    end else begin
                        n_prev_tab = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier  <= '0;
            r_tab      <= '0;
            r_sidx     <= '0;
            r_off      <= '0;
            r_fz       <= 1'b0;
            r_hr       <= 1'b0;
            r_np       <= '0;
            r_ns       <= 1'b0;
            r_prev_tab <= 1'b0;
            r_hdr      <= 1'b0;
            r_start    <= 1'b1;
            r_open     <= 1'b0;
        end else begin
            r_carrier  <= n_carrier;
            r_tab      <= n_tab;
            r_sidx     <= n_sidx;
            r_off      <= n_off;
            r_fz       <= n_fz;
            r_hr       <= n_hr;
            r_np       <= n_np;
            r_ns       <= n_ns;
            r_prev_tab <= n_prev_tab;
            r_hdr      <= n_hdr;
            r_start    <= n_start;
            r_open     <= n_open;
        end
    end

    assign o_line.done     = w_done;
    assign o_line.carriers = w_final;

endmodule

`default_nettype wire

// File: rtl/gcm_matrix.sv
`default_nettype none

module gcm_matrix (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gcm_pkg::t_line i_line,
    input  wire logic           i_rd_req,
    input  wire gcm_pkg::t_addr i_rd_addr,
    output logic                o_busy,
    output logic                o_rd_valid,
    output gcm_pkg::t_count     o_rd_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    gcm_pkg::t_count    mem [2**gcm_pkg::ADDR_W];

    logic [1:0]         r_state, n_state;
    gcm_pkg::t_addr     r_idx, n_idx;
    gcm_pkg::t_carriers r_car, n_car;
    logic               r_wb_valid;
    gcm_pkg::t_addr     r_wb_addr;
    logic               r_rd_valid;
    gcm_pkg::t_count    r_rd_data;

    gcm_pkg::t_sample   w_row;
    gcm_pkg::t_sample   w_col;
    logic               w_last;
    logic               w_hit;
    logic               w_re;
    gcm_pkg::t_addr     w_raddr;
    logic               w_we;
    gcm_pkg::t_addr     w_waddr;
    gcm_pkg::t_count    w_wdata;
    gcm_pkg::t_count    w_sat;

    always_comb begin
        w_row   = r_idx[gcm_pkg::ADDR_W-1:gcm_pkg::SAMPLE_W];
        w_col   = r_idx[gcm_pkg::SAMPLE_W-1:0];
        w_last  = (r_idx == '1);
        w_hit   = (r_state == ST_SWEEP) && r_car[w_row] && r_car[w_col];
        w_re    = w_hit || ((r_state == ST_IDLE) && i_rd_req);
        w_raddr = (r_state == ST_SWEEP) ? r_idx : i_rd_addr;
        // Saturating increment of the counter read in the previous cycle.
        w_sat   = (r_rd_data == '1) ? r_rd_data : r_rd_data + gcm_pkg::t_count'(1);
        w_we    = (r_state == ST_CLEAR) || r_wb_valid;
        w_waddr = (r_state == ST_CLEAR) ? r_idx : r_wb_addr;
        w_wdata = (r_state == ST_CLEAR) ? '0 : w_sat;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_car   = r_car;
        unique case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + gcm_pkg::t_addr'(1);
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_line.done) begin
                    n_state = ST_SWEEP;
                    n_idx   = '0;
                    n_car   = i_line.carriers;
                end
            end
            ST_SWEEP: begin
                n_idx = r_idx + gcm_pkg::t_addr'(1);
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_idx      <= '0;
            r_wb_valid <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_wb_valid <= w_hit;
            r_rd_valid <= (r_state == ST_IDLE) && i_rd_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_car     <= n_car;
        r_wb_addr <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_rd_valid = r_rd_valid;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/genotype_cooccurrence_matrix_core.sv
// Genotype co-occurrence counter. Each input word either streams one byte of
// tab-separated variant-call text (action 0) or reads one 32-bit pair counter
// (action 1, row/col sample). A read's word passes through the matrix read
// register into the output register; the input stalls until the word has
// moved into the output register and while that register holds a word not
// yet taken. A newline that ends a data line starts a sweep over the 64x64
// counter memory, one address a cycle through a single read-increment-write
// path, which holds the input off until the sweep and its drain are done.
// After reset the memory is zeroed one entry a cycle, so no word is accepted
// until the clear is done; num_samples may be written at any time the block
// is idle.
`default_nettype none

`include "genotype_cooccurrence_matrix_core_defines.svh"

module genotype_cooccurrence_matrix_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    gcm_in_if.sink              i_in,
    gcm_out_if.source           o_out,
    input  wire logic           i_cfg_wr_en,
    input  wire gcm_pkg::t_num  i_cfg_wr_data
);

    gcm_pkg::t_num   r_num_samples;
    logic            r_out_valid;
    gcm_pkg::t_count r_out_data;

    logic            w_acc;
    logic            w_byte_en;
    logic            w_rd_req;
    gcm_pkg::t_addr  w_rd_addr;
    gcm_pkg::t_line  w_line;
    logic            w_busy;
    logic            w_rd_valid;
    gcm_pkg::t_count w_rd_data;

    // Hold off while the matrix is busy (clearing, sweeping or draining) or while a read word is still on its way out.
    assign i_in.ready = !w_busy && !w_rd_valid && (!r_out_valid || o_out.ready);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_byte_en  = w_acc && (i_in.data.action == gcm_pkg::ACT_STREAM);
    assign w_rd_req   = w_acc && (i_in.data.action == gcm_pkg::ACT_READ);
    assign w_rd_addr  = {i_in.data.row_sample, i_in.data.col_sample};

    gcm_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_en     (w_byte_en),
        .i_byte        (i_in.data.text_byte),
        .i_num_samples (r_num_samples),
        .o_line        (w_line)
    );

    gcm_matrix u_matrix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_line     (w_line),
        .i_rd_req   (w_rd_req),
        .i_rd_addr  (w_rd_addr),
        .o_busy     (w_busy),
        .o_rd_valid (w_rd_valid),
        .o_rd_data  (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_samples <= gcm_pkg::MAX_SAMPLES_NUM;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_num_samples <= i_cfg_wr_data;
            end
            if (w_rd_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_valid) begin
            r_out_data <= w_rd_data;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.data.pair_count = r_out_data;

    `GCM_ASSERT_NEXT(a_read_returns, w_rd_req, w_rd_valid)
    `GCM_ASSERT_IMPLY(a_no_overwrite, w_rd_valid, !r_out_valid)
    `GCM_ASSERT_NEXT(a_line_sweeps, w_line.done, w_busy)

endmodule

`default_nettype wire

// File: dv/tb_genotype_cooccurrence_matrix_core.sv
`timescale 1ns / 1ps

module tb_genotype_cooccurrence_matrix_core;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned SWEEP_WAIT   = 4200;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_BUDGET = 120;
    localparam int unsigned NUM_PHASES   = 9;

    typedef enum int {STIM_TEXT, STIM_BYTE, STIM_READ} t_stim_kind;

    typedef enum int {
        GT_HOM_REF, GT_HET, GT_HOM_ALT, GT_PHASED_REF, GT_NAN, GT_MISSING,
        GT_EMPTY, GT_SHORT, GT_REF_ANNOT, GT_EMBEDDED_NAN, GT_RANDOM, GT_COUNT
    } t_gt_shape;

    typedef enum int {LINE_DATA, LINE_HEADER, LINE_BROKEN, LINE_NOISE} t_line_kind;

    typedef struct {
        t_stim_kind       kind;
        string            text;
        logic [7:0]       raw;
        gcm_pkg::t_sample row;
        gcm_pkg::t_sample col;
        bit               fixed;
        gcm_pkg::t_count  fixed_val;
    } t_stim_row;

    localparam string VCF_PREFIX = "chr1\t100\trs1\tA\tG\t50\tPASS\t.\tGT\t";
    localparam string GT_ALPHABET = "0Na1/|.";
    localparam string PREFIX_ALPHABET = "ACGT0123456789.:chrPS";

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    gcm_pkg::t_num cfg_wr_data;

    gcm_in_if  in_if ();
    gcm_out_if out_if ();

    genotype_cooccurrence_matrix_core u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted block state
    gcm_pkg::t_count    pair_tally [gcm_pkg::MAX_SAMPLES*gcm_pkg::MAX_SAMPLES];
    gcm_pkg::t_carriers line_carriers;
    int unsigned        tabs_seen;
    int unsigned        field_idx;
    int unsigned        byte_pos;
    int unsigned        nan_state;
    bit                 lead_zero, hom_ref, nan_hit;
    bit                 after_tab, header_line, line_start, in_field;
    gcm_pkg::t_num      num_cfg;

    gcm_pkg::t_count    pending_counts [$];
    logic [7:0]         line_buf [$];
    bit                 idle_on;
    int unsigned        hold_request = 0;
    int unsigned        check_idx = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;

    t_stim_row directed_rows [23] = '{
        '{STIM_READ, "", 8'd0, 6'd0,  6'd0,  1'b1, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd63, 6'd63, 1'b1, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd63, 6'd0,  1'b1, 32'd0},
        '{STIM_TEXT, "#CHROM\tPOS\tID\tREF\tALT\tQUAL\tFILTER\tINFO\tFORMAT\tS0\tS1\n",
          8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd0,  6'd0,  1'b1, 32'd0},
        '{STIM_TEXT, "\n", 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_TEXT, {VCF_PREFIX, "0/0\t0/1\t1/1\tNaN\t0\t\t./.\t0|0:5\t\n"},
          8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd1,  6'd2,  1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd5,  6'd5,  1'b0, 32'd0},
        '{STIM_TEXT, {VCF_PREFIX, "00\t0\tNa\txNaNy\t"}, 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_BYTE, "", 8'd0,   6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_BYTE, "", 8'd13,  6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_BYTE, "", 8'd255, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_TEXT, "\t0", 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_BYTE, "", 8'd13,  6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_TEXT, "0\t1/0\n", 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd2,  6'd2,  1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd4,  6'd6,  1'b0, 32'd0},
        '{STIM_TEXT, "no\ttabs\there\n", 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_TEXT, {VCF_PREFIX, "N\tNNaN\t0/0\n"}, 8'd0, 6'd0, 6'd0, 1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd0,  6'd1,  1'b0, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd63, 6'd63, 1'b1, 32'd0},
        '{STIM_READ, "", 8'd0, 6'd7,  6'd7,  1'b0, 32'd0}
    };

    gcm_pkg::t_num phase_nums [NUM_PHASES] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd64,
                                                7'd7, 7'd33, 7'd63};

    // ---------------- predictor ----------------

    function automatic void clear_line_state();
        line_carriers = '0;
        tabs_seen     = 0;
        field_idx     = 0;
        byte_pos      = 0;
        lead_zero     = 1'b0;
        hom_ref       = 1'b0;
        nan_state     = 0;
        nan_hit       = 1'b0;
        after_tab     = 1'b0;
        header_line   = 1'b0;
        line_start    = 1'b1;
        in_field      = 1'b0;
    endfunction

    function automatic void finish_field();
        int unsigned lim;
        lim = (num_cfg > gcm_pkg::MAX_SAMPLES) ? gcm_pkg::MAX_SAMPLES : num_cfg;
        if (field_idx < lim && !nan_hit && !hom_ref)
            line_carriers[field_idx] = 1'b1;
        if (field_idx < gcm_pkg::MAX_SAMPLES)
            field_idx++;
        in_field = 1'b0;
    endfunction

    function automatic void take_field_byte(logic [7:0] b);
        if (byte_pos == 0)
            lead_zero = (b == gcm_pkg::ZERO_BYTE);
        else if (byte_pos == 2 && lead_zero && b == gcm_pkg::ZERO_BYTE)
            hom_ref = 1'b1;
        if (byte_pos < 3)
            byte_pos++;
        if (nan_state == 2 && b == gcm_pkg::BIG_N_BYTE)
            nan_hit = 1'b1;
        if (nan_state == 1 && b == gcm_pkg::SMALL_A_BYTE)
            nan_state = 2;
        else
            nan_state = (b == gcm_pkg::BIG_N_BYTE) ? 1 : 0;
    endfunction

    // Saturating increment of every carrier pair, diagonal included
    function automatic void bump_pairs();
        for (int i = 0; i < gcm_pkg::MAX_SAMPLES; i++) begin
            if (line_carriers[i]) begin
                for (int j = 0; j < gcm_pkg::MAX_SAMPLES; j++) begin
                    if (line_carriers[j] && pair_tally[i*gcm_pkg::MAX_SAMPLES+j] != '1)
                        pair_tally[i*gcm_pkg::MAX_SAMPLES+j]++;
                end
            end
        end
    endfunction

    function automatic void parse_text_byte(logic [7:0] b);
        if (b == gcm_pkg::NL_BYTE) begin
            if (!header_line) begin
                if (in_field)
                    finish_field();
                bump_pairs();
            end
            clear_line_state();
            return;
        end
        if (line_start) begin
            line_start = 1'b0;
            if (b == gcm_pkg::HASH_BYTE)
                header_line = 1'b1;
        end
        if (header_line)
            return;
        if (after_tab && tabs_seen >= gcm_pkg::FIRST_SAMPLE_TAB) begin
            in_field  = 1'b1;
            byte_pos  = 0;
            lead_zero = 1'b0;
            hom_ref   = 1'b0;
            nan_state = 0;
            nan_hit   = 1'b0;
        end
        if (in_field) begin
            if (b == gcm_pkg::TAB_BYTE)
                finish_field();
            else
                take_field_byte(b);
        end
        if (b == gcm_pkg::TAB_BYTE) begin
            if (tabs_seen < 255)
                tabs_seen++;
            after_tab = 1'b1;
        end else begin
            after_tab = 1'b0;
        end
    endfunction

    // ---------------- stimulus ----------------

    task automatic send_word(input gcm_pkg::t_in_word w, input bit fixed,
                             input gcm_pkg::t_count fixed_val);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        if (w.action == gcm_pkg::ACT_READ)
            pending_counts = {pending_counts,
                              fixed ? fixed_val : pair_tally[{w.row_sample, w.col_sample}]};
        else
            parse_text_byte(w.text_byte);
    endtask

    task automatic send_text_byte(input logic [7:0] b);
        gcm_pkg::t_in_word w;
        w.action     = gcm_pkg::ACT_STREAM;
        w.text_byte  = b;
        w.row_sample = gcm_pkg::t_sample'($urandom_range(0, 63));
        w.col_sample = gcm_pkg::t_sample'($urandom_range(0, 63));
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_read(input gcm_pkg::t_sample row, input gcm_pkg::t_sample col,
                             input bit fixed, input gcm_pkg::t_count fixed_val);
        gcm_pkg::t_in_word w;
        w.action     = gcm_pkg::ACT_READ;
        w.text_byte  = 8'($urandom_range(0, 255));
        w.row_sample = row;
        w.col_sample = col;
        send_word(w, fixed, fixed_val);
    endtask

    task automatic send_random_read();
        gcm_pkg::t_sample row, col;
        row = ($urandom_range(0, 1) != 0) ? gcm_pkg::t_sample'($urandom_range(0, 63))
                                          : gcm_pkg::t_sample'($urandom_range(0, 7));
        col = ($urandom_range(0, 1) != 0) ? gcm_pkg::t_sample'($urandom_range(0, 63))
                                          : gcm_pkg::t_sample'($urandom_range(0, 7));
        send_read(row, col, 1'b0, '0);
    endtask

    task automatic write_num(input gcm_pkg::t_num value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        num_cfg = value;
    endtask

    // Drop valid, wait for every read to come back, then let a line sweep finish
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (check_idx != pending_counts.size())
            @(posedge clk);
        repeat (SWEEP_WAIT) @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == gcm_pkg::TAB_BYTE || b == gcm_pkg::NL_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] gt_byte();
        if ($urandom_range(0, 3) == 0)
            return plain_byte();
        return GT_ALPHABET[$urandom_range(0, GT_ALPHABET.len() - 1)];
    endfunction

    function automatic void add_byte(logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void push_prefix_fields(int unsigned tabs);
        repeat (tabs) begin
            repeat ($urandom_range(0, 4))
                add_byte(PREFIX_ALPHABET[$urandom_range(0, PREFIX_ALPHABET.len() - 1)]);
            add_byte(gcm_pkg::TAB_BYTE);
        end
    endfunction

    function automatic void push_genotype();
        t_gt_shape shape;
        shape = t_gt_shape'($urandom_range(0, GT_COUNT - 1));
        case (shape)
            GT_HOM_REF:    push_text("0/0");
            GT_HET:        push_text("0/1");
            GT_HOM_ALT:    push_text("1/1");
            GT_PHASED_REF: push_text("0|0");
            GT_NAN:        push_text("NaN");
            GT_MISSING:    push_text("./.");
            GT_EMPTY:      ;
            GT_SHORT: begin
                add_byte(($urandom_range(0, 2) != 0) ? gcm_pkg::ZERO_BYTE : gt_byte());
                if ($urandom_range(0, 1) != 0)
                    add_byte(gt_byte());
            end
            GT_REF_ANNOT: begin
                push_text("0/0:");
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(48, 57)));
            end
            GT_EMBEDDED_NAN: begin
                repeat ($urandom_range(0, 2)) add_byte(gt_byte());
                push_text("NaN");
                repeat ($urandom_range(0, 2)) add_byte(gt_byte());
            end
            default: begin
                repeat ($urandom_range(1, 6)) add_byte(gt_byte());
            end
        endcase
    endfunction

    function automatic void build_line(t_line_kind kind, gcm_pkg::t_num num);
        int unsigned lim, fields;
        line_buf.delete();
        lim = (num > gcm_pkg::MAX_SAMPLES) ? gcm_pkg::MAX_SAMPLES : num;
        case (kind)
            LINE_DATA: begin
                push_prefix_fields(gcm_pkg::FIRST_SAMPLE_TAB);
                fields = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72)
                                                      : $urandom_range(0, lim + 2);
                for (int k = 0; k < fields; k++) begin
                    if (k > 0)
                        add_byte(gcm_pkg::TAB_BYTE);
                    push_genotype();
                end
                if ($urandom_range(0, 7) == 0)
                    add_byte(gcm_pkg::TAB_BYTE);
            end
            LINE_HEADER: begin
                add_byte(gcm_pkg::HASH_BYTE);
                repeat ($urandom_range(0, 30))
                    add_byte(($urandom_range(0, 4) == 0) ? gcm_pkg::TAB_BYTE : plain_byte());
            end
            LINE_BROKEN: begin
                push_prefix_fields($urandom_range(0, gcm_pkg::FIRST_SAMPLE_TAB - 1));
                push_genotype();
            end
            default: begin
                repeat ($urandom_range(1, 40))
                    add_byte(($urandom_range(0, 4) == 0) ? gcm_pkg::TAB_BYTE
                                                         : 8'($urandom_range(0, 255)));
            end
        endcase
        add_byte(gcm_pkg::NL_BYTE);
    endfunction

    task automatic run_phase(input gcm_pkg::t_num num, input bit idle, input bit pressure);
        int unsigned items;
        int unsigned pick;
        t_line_kind  kind;
        write_num(num);
        idle_on = idle;
        items = 0;
        if (pressure) begin
            // Hold the output off while reads keep coming, so the input backs up
            hold_request++;
            repeat (24) send_random_read();
            items += 24;
        end
        while (items < PHASE_BUDGET) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 72) ? LINE_DATA : (pick < 80) ? LINE_HEADER :
                   (pick < 88) ? LINE_BROKEN : LINE_NOISE;
            build_line(kind, num);
            foreach (line_buf[i]) begin
                if ($urandom_range(0, 32) == 0) begin
                    send_random_read();
                    items++;
                end
                send_text_byte(line_buf[i]);
            end
            items += line_buf.size();
            repeat ($urandom_range(1, 5)) begin
                send_random_read();
                items++;
            end
        end
        wait_idle();
    endtask

    // ---------------- result checking ----------------

    initial begin
        gcm_pkg::t_count want;
        int unsigned     hold_left;
        int unsigned     holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (check_idx >= pending_counts.size()) begin
                    $error("pair_count: word with none expected, actual %0d",
                           out_if.data.pair_count);
                    mismatch_count++;
                end else begin
                    want = pending_counts[check_idx];
                    check_idx++;
                    if (out_if.data.pair_count !== want) begin
                        $error("pair_count mismatch: expected %0d, actual %0d",
                               want, out_if.data.pair_count);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_request != holds_done) begin
                holds_done   = hold_request;
                hold_left    = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                hold_left    = $urandom_range(0, 16);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        idle_on        = 1'b0;
        num_cfg        = gcm_pkg::MAX_SAMPLES_NUM;
        foreach (pair_tally[i])
            pair_tally[i] = '0;
        clear_line_state();

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // Let the counter memory clear before touching the register
        repeat (SWEEP_WAIT) @(posedge clk);

        write_num(gcm_pkg::MAX_SAMPLES_NUM);
        idle_on = 1'b1;
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                STIM_TEXT: begin
                    for (int i = 0; i < directed_rows[r].text.len(); i++)
                        send_text_byte(directed_rows[r].text[i]);
                end
                STIM_BYTE: send_text_byte(directed_rows[r].raw);
                default:   send_read(directed_rows[r].row, directed_rows[r].col,
                                     directed_rows[r].fixed, directed_rows[r].fixed_val);
            endcase
        end
        wait_idle();

        foreach (phase_nums[p])
            run_phase(phase_nums[p], p != NUM_PHASES - 1, p == 3);

        if (check_idx != pending_counts.size())
            $error("pair_count: %0d expected words never arrived",
                   pending_counts.size() - check_idx);
        if (mismatch_count == 0 && check_idx == pending_counts.size())
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gcm_pkg.sv
rtl/gcm_ifs.sv
rtl/gcm_parse.sv
rtl/gcm_matrix.sv
rtl/genotype_cooccurrence_matrix_core.sv
dv/tb_genotype_cooccurrence_matrix_core.sv
